FILE: hdl/open_addressing_probe_generator_defines.svh
// assertion macros for the probe generator checker
`ifndef OPEN_ADDRESSING_PROBE_GENERATOR_DEFINES_SVH
`define OPEN_ADDRESSING_PROBE_GENERATOR_DEFINES_SVH

// property must hold at every edge outside reset
`define OAPG_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("oapg check failed");

// condition must never be seen outside reset
`define OAPG_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("oapg forbidden condition");

`endif

FILE: hdl/oapg_pkg.sv
// ----------------------------------------------------------------------------
// oapg_pkg
// types, constants and step functions of the probe generator
// ----------------------------------------------------------------------------
`default_nettype none

package oapg_pkg;

	localparam int KEY_W      = 33;
	localparam int IDX_W      = 32;
	localparam int LOG2_W     = 6;
	localparam int STEP_W     = 31;
	localparam int CFG_IDX_W  = 3;
	localparam int LO_W       = 16;
	localparam int NUM_W      = 68;
	localparam int RED_STEPS  = 2;
	localparam int RED_STAGES = NUM_W / RED_STEPS;
	localparam int HASH_STAGES = 2 + RED_STAGES;
	localparam int ALL_STAGES  = HASH_STAGES + 2;

	typedef enum logic [1:0] {
		SCH_LINEAR = 2'd0,
		SCH_QUAD   = 2'd1,
		SCH_STEP   = 2'd2,
		SCH_DOUBLE = 2'd3
	} scheme_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCHEME = 3'd0,
		REG_LOG2   = 3'd1,
		REG_PRIME  = 3'd2,
		REG_MULT1  = 3'd3,
		REG_OFF1   = 3'd4,
		REG_MULT2  = 3'd5,
		REG_OFF2   = 3'd6,
		REG_STEP   = 3'd7
	} cfg_idx_t;

	// one restoring step: shift in a bit, subtract the modulus if it fits
	function automatic logic [KEY_W-1:0] red_step(input logic [KEY_W-1:0] r,
		input logic b, input logic [KEY_W-1:0] m);
		logic [KEY_W:0] t;
		t = {r, b};
		if (t >= {1'b0, m}) begin
			t = t - {1'b0, m};
		end
		return t[KEY_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hdl/oapg_hash.sv
// ----------------------------------------------------------------------------
// oapg_hash
// pipelined universal hash (a*key+b) mod p, exact product, two bits a stage
// ----------------------------------------------------------------------------
`default_nettype none

module oapg_hash (
	input  wire logic                                 clk,
	input  wire logic [oapg_pkg::HASH_STAGES-1:0]     en,
	input  wire logic [oapg_pkg::KEY_W-1:0]           key,
	input  wire logic [oapg_pkg::KEY_W-1:0]           mult,
	input  wire logic [oapg_pkg::KEY_W-1:0]           offs,
	input  wire logic [oapg_pkg::KEY_W-1:0]           modulus,
	output logic      [oapg_pkg::KEY_W-1:0]           hash
);

	localparam int KW = oapg_pkg::KEY_W;
	localparam int LW = oapg_pkg::LO_W;
	localparam int P0_W = KW + LW;
	localparam int P1_W = KW + KW - LW;
	localparam int NW = oapg_pkg::NUM_W;
	localparam int RS = oapg_pkg::RED_STEPS;
	localparam int RN = oapg_pkg::RED_STAGES;

	logic [P0_W-1:0] p0_s1;
	logic [P1_W-1:0] p1_s1;
	logic [NW-1:0]   sum_s2;
	logic [NW-1:0]   num_s [RN];
	logic [KW-1:0]   rem_s [RN];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p0_s1 <= P0_W'(mult) * P0_W'(key[LW-1:0]);
			p1_s1 <= P1_W'(mult) * P1_W'(key[KW-1:LW]);
		end
		if (en[1]) begin
			sum_s2 <= NW'(p0_s1) + (NW'(p1_s1) << LW) + NW'(offs);
		end
	end

	for (genvar t = 0; t < RN; t++) begin : g_red
		logic [NW-1:0] num_in;
		logic [KW-1:0] rem_in;
		logic [KW-1:0] rem_nx;

		if (t == 0) begin : g_first
			assign num_in = sum_s2;
			assign rem_in = '0;
		end else begin : g_rest
			assign num_in = num_s[t-1];
			assign rem_in = rem_s[t-1];
		end

		always_comb begin
			rem_nx = rem_in;
			for (int j = 0; j < RS; j++) begin
				rem_nx = oapg_pkg::red_step(rem_nx, num_in[NW-1-RS*t-j], modulus);
			end
		end

		always_ff @(posedge clk) begin
			if (en[t+2]) begin
				num_s[t] <= num_in;
				rem_s[t] <= rem_nx;
			end
		end
	end

	// zero modulus: low bits of the exact sum
	assign hash = (modulus == '0) ? num_s[RN-1][KW-1:0] : rem_s[RN-1];

endmodule

`default_nettype wire

FILE: hdl/open_addressing_probe_generator.sv
// ----------------------------------------------------------------------------
// open_addressing_probe_generator
// table slot for a key and probe number under four probe schemes
// ----------------------------------------------------------------------------
// Takes one beat per clock while the output is not stalled and returns one
// slot beat per input beat, in order. The exact 68-bit modular reduction
// of a*key+b retires two bits per pipeline stage (34 stages), with a
// multiply stage and an add stage before it and two probe stages after.
// Both hashes run side by side. Bubbles close up while the output waits.
// Configuration writes are always accepted and must be made while idle.
`default_nettype none

module open_addressing_probe_generator #(
	parameter int MAX_TABLE_LOG2 = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [oapg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [oapg_pkg::KEY_W-1:0]           cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [oapg_pkg::KEY_W-1:0]           key,
	input  wire logic [oapg_pkg::IDX_W-1:0]           probe_number,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic      [oapg_pkg::IDX_W-1:0]           slot_index
);

	localparam int KW = oapg_pkg::KEY_W;
	localparam int IW = oapg_pkg::IDX_W;
	localparam int HS = oapg_pkg::HASH_STAGES;
	localparam int NS = oapg_pkg::ALL_STAGES;
	localparam int LGW = oapg_pkg::LOG2_W;

	oapg_pkg::scheme_t            scheme_q;
	logic [LGW-1:0]               log2_q;
	logic [KW-1:0]                prime_q;
	logic [KW-1:0]                mult1_q;
	logic [KW-1:0]                off1_q;
	logic [KW-1:0]                mult2_q;
	logic [KW-1:0]                off2_q;
	logic [oapg_pkg::STEP_W-1:0]  step_q;

	logic [NS-1:0]  vld_s;
	logic [NS-1:0]  rdy;
	logic [IW-1:0]  pn_s [HS];
	logic [KW-1:0]  h1;
	logic [KW-1:0]  h2;
	logic [LGW-1:0] k_eff;
	logic [IW-1:0]  mask;
	logic [KW-1:0]  mul_y;
	logic [IW-1:0]  base_s1;
	logic [KW-1:0]  prod_s1;
	logic [IW-1:0]  offs;
	logic [IW-1:0]  slot_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scheme_q <= oapg_pkg::SCH_LINEAR;
			log2_q   <= LGW'(10);
			prime_q  <= 33'h1_0000_000F;
			mult1_q  <= KW'(1);
			off1_q   <= '0;
			mult2_q  <= KW'(1);
			off2_q   <= '0;
			step_q   <= oapg_pkg::STEP_W'(511);
		end else if (cfg_valid && cfg_ready) begin
			unique case (oapg_pkg::cfg_idx_t'(cfg_index))
				oapg_pkg::REG_SCHEME: scheme_q <= oapg_pkg::scheme_t'(cfg_data[1:0]);
				oapg_pkg::REG_LOG2:   log2_q   <= cfg_data[LGW-1:0];
				oapg_pkg::REG_PRIME:  prime_q  <= cfg_data;
				oapg_pkg::REG_MULT1:  mult1_q  <= cfg_data;
				oapg_pkg::REG_OFF1:   off1_q   <= cfg_data;
				oapg_pkg::REG_MULT2:  mult2_q  <= cfg_data;
				oapg_pkg::REG_OFF2:   off2_q   <= cfg_data;
				oapg_pkg::REG_STEP:   step_q   <= cfg_data[oapg_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// per-stage ready, bubbles close up
	always_comb begin
		rdy[NS-1] = !vld_s[NS-1] || out_ready;
		for (int j = NS - 2; j >= 0; j--) begin
			rdy[j] = !vld_s[j] || rdy[j+1];
		end
	end

	assign in_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int j = 1; j < NS; j++) begin
				if (rdy[j]) begin
					vld_s[j] <= vld_s[j-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			pn_s[0] <= probe_number;
		end
		for (int j = 1; j < HS; j++) begin
			if (rdy[j]) begin
				pn_s[j] <= pn_s[j-1];
			end
		end
	end

	oapg_hash u_hash1 (
		.clk     (clk),
		.en      (rdy[HS-1:0]),
		.key     (key),
		.mult    (mult1_q),
		.offs    (off1_q),
		.modulus (prime_q),
		.hash    (h1)
	);

	oapg_hash u_hash2 (
		.clk     (clk),
		.en      (rdy[HS-1:0]),
		.key     (key),
		.mult    (mult2_q),
		.offs    (off2_q),
		.modulus (prime_q),
		.hash    (h2)
	);

	always_comb begin
		if (log2_q == '0) begin
			k_eff = LGW'(1);
		end else if (log2_q > LGW'(MAX_TABLE_LOG2)) begin
			k_eff = LGW'(MAX_TABLE_LOG2);
		end else begin
			k_eff = log2_q;
		end
		mask = ~({IW{1'b1}} << k_eff);
	end

	always_comb begin
		case (scheme_q)
			oapg_pkg::SCH_LINEAR: mul_y = KW'(1);
			oapg_pkg::SCH_QUAD:   mul_y = KW'(pn_s[HS-1]) + KW'(1);
			oapg_pkg::SCH_STEP:   mul_y = KW'(step_q);
			default:              mul_y = {1'b0, h2[IW-1:0] & mask};
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy[HS]) begin
			base_s1 <= h1[IW-1:0] & mask;
			prod_s1 <= KW'({1'b0, pn_s[HS-1]} * mul_y);
		end
	end

	// quadratic: i(i+1)/2 is the product shifted down one
	assign offs = (scheme_q == oapg_pkg::SCH_QUAD) ? prod_s1[KW-1:1] : prod_s1[IW-1:0];

	always_ff @(posedge clk) begin
		if (rdy[HS+1]) begin
			slot_s2 <= (base_s1 + offs) & mask;
		end
	end

	assign out_valid  = vld_s[NS-1];
	assign slot_index = slot_s2;

endmodule

`default_nettype wire

FILE: hdl/oapg_checker.sv
// ----------------------------------------------------------------------------
// oapg_checker
// port-level checks of the probe generator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "open_addressing_probe_generator_defines.svh"

module oapg_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           cfg_ready,
	input wire logic                           in_ready,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [oapg_pkg::IDX_W-1:0]     slot_index
);

	// a stalled result beat holds
	`OAPG_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(slot_index))
	// a free output frees the whole pipeline
	`OAPG_ASSERT(a_rdy_out, clk, arst_n, out_ready |-> in_ready)
	`OAPG_ASSERT(a_rdy_empty, clk, arst_n, !out_valid |-> in_ready)
	`OAPG_NEVER(a_cfg_block, clk, arst_n, !cfg_ready)

endmodule

bind open_addressing_probe_generator oapg_checker u_oapg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_ready  (cfg_ready),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.slot_index (slot_index)
);

`default_nettype wire
